>>> rtl/dvs_pkg.sv
// ----------------------------------------------------------------------------
// dvs_pkg
// Shared types, field widths, register codes and reset values for the
// detection vote smoother.
// ----------------------------------------------------------------------------
package dvs_pkg;

    localparam int NUM_CLASSES_DEF  = 4;
    localparam int WINDOW_DEPTH_DEF = 8;

    localparam int LOGIT_W    = 8;
    localparam int NUM_LOGITS = 4;
    localparam int WINNER_W   = 2;
    localparam int CLASS_W    = 2;
    localparam int CONF_W     = 7;
    localparam int VOTE_OUT_W = 4;
    localparam int RUN_W      = 4;
    localparam int HOLD_W     = 8;
    localparam int MASK_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [RUN_W-1:0] RUN_CAP = 4'd15;

    localparam logic signed [LOGIT_W-1:0] THRESH_RST    = 8'sd40;
    localparam logic [3:0]                MIN_VOTES_RST = 4'd5;
    localparam logic [RUN_W-1:0]          MIN_RUN_RST   = 4'd2;
    localparam logic [HOLD_W-1:0]         HOLDOFF_RST   = 8'd12;
    localparam logic [MASK_W-1:0]         MASK_RST      = 4'hC;
    localparam logic                      ENABLE_RST    = 1'b1;

    typedef logic signed [LOGIT_W-1:0] t_logit;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESH    = 3'd0,
        REG_MIN_VOTES = 3'd1,
        REG_MIN_RUN   = 3'd2,
        REG_HOLDOFF   = 3'd3,
        REG_MASK      = 3'd4,
        REG_ENABLE    = 3'd5
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_DECIDE
    } t_state;

endpackage

>>> rtl/dvs_channels.sv
// ----------------------------------------------------------------------------
// dvs channels
// Valid/ready channel interfaces for frame input, detection output and
// register writes.
// ----------------------------------------------------------------------------
interface dvs_in_if import dvs_pkg::*; ();
    logic                valid;
    logic                ready;
    t_logit              logit_0;
    t_logit              logit_1;
    t_logit              logit_2;
    t_logit              logit_3;
    logic [WINNER_W-1:0] frame_winner;

    modport source (
        output valid, logit_0, logit_1, logit_2, logit_3, frame_winner,
        input  ready
    );
    modport sink (
        input  valid, logit_0, logit_1, logit_2, logit_3, frame_winner,
        output ready
    );
endinterface

interface dvs_out_if import dvs_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  fire;
    logic [CLASS_W-1:0]    event_class;
    logic [CONF_W-1:0]     confidence;
    logic [VOTE_OUT_W-1:0] vote_count;

    modport source (
        output valid, fire, event_class, confidence, vote_count,
        input  ready
    );
    modport sink (
        input  valid, fire, event_class, confidence, vote_count,
        output ready
    );
endinterface

interface dvs_cfg_if import dvs_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

>>> rtl/detection_vote_smoother_unit.sv
// ----------------------------------------------------------------------------
// detection_vote_smoother_unit
// Flow: a frame word is accepted in ST_IDLE, ST_SUM steps through the classes,
//   then ST_DECIDE registers the result word once the output side is free.
// Throughput: no new frame word until that result is committed; one shared
//   sum/average/compare unit steps through the classes, one per cycle.
// Reset: synchronous active low; clears sums, vote counts, pointers, run,
//   hold-off and restores register defaults. History memories are not cleared.
// ----------------------------------------------------------------------------
module detection_vote_smoother_unit import dvs_pkg::*; #(
    parameter int NUM_CLASSES  = NUM_CLASSES_DEF,
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dvs_cfg_if.sink    i_cfg,
    dvs_in_if.sink     i_in,
    dvs_out_if.source  o_out
);

    localparam int SH     = $clog2(WINDOW_DEPTH);
    localparam int SUM_W  = LOGIT_W + SH;
    localparam int CLS_W  = $clog2(NUM_CLASSES);
    localparam int PTR_W  = $clog2(WINDOW_DEPTH);
    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
    localparam int HIST_W = NUM_LOGITS * LOGIT_W;

    localparam logic [CLS_W-1:0]  LAST_CLS   = CLS_W'(NUM_CLASSES - 1);
    localparam logic [PTR_W-1:0]  LAST_PTR   = PTR_W'(WINDOW_DEPTH - 1);
    localparam logic [FILL_W-1:0] DEPTH_FILL = FILL_W'(WINDOW_DEPTH);

    // configuration registers
    logic signed [LOGIT_W-1:0] r_cfg_thresh;
    logic [3:0]                r_cfg_min_votes;
    logic [RUN_W-1:0]          r_cfg_min_run;
    logic [HOLD_W-1:0]         r_cfg_holdoff;
    logic [MASK_W-1:0]         r_cfg_mask;
    logic                      r_cfg_en;

    // history memories
    logic [HIST_W-1:0]   r_logit_mem  [WINDOW_DEPTH];
    logic [WINNER_W-1:0] r_winner_mem [WINDOW_DEPTH];

    t_state r_state, n_state;

    logic [HIST_W-1:0]         r_in_pack, r_old_pack;
    logic [WINNER_W-1:0]       r_in_winner, r_old_winner;
    logic [PTR_W-1:0]          r_wp, n_wp;
    logic [FILL_W-1:0]         r_fill, n_fill;
    logic                      r_old_valid, n_old_valid;
    logic [CLS_W-1:0]          r_cls, n_cls;
    logic [CLS_W-1:0]          r_best, n_best;
    logic signed [LOGIT_W-1:0] r_best_val, n_best_val;
    logic signed [SUM_W-1:0]   r_sum   [NUM_CLASSES];
    logic signed [SUM_W-1:0]   n_sum   [NUM_CLASSES];
    logic [FILL_W-1:0]         r_votes [NUM_CLASSES];
    logic [FILL_W-1:0]         n_votes [NUM_CLASSES];
    logic [RUN_W-1:0]          r_run, n_run;
    logic [CLS_W-1:0]          r_last, n_last;
    logic [HOLD_W-1:0]         r_holdoff, n_holdoff;
    logic                      r_out_valid, n_out_valid;
    logic                      r_fire, n_fire;
    logic [CLASS_W-1:0]        r_class, n_class;
    logic [CONF_W-1:0]         r_conf, n_conf;
    logic [VOTE_OUT_W-1:0]     r_vote, n_vote;

    logic                      w_in_acc;
    logic                      w_sum_en;
    logic                      w_decide;
    logic                      w_out_free;
    logic                      w_commit;
    logic [HIST_W-1:0]         w_in_pack;
    logic [1:0]                w_lg_idx;
    logic                      w_lg_live;
    t_logit                    w_lg;
    t_logit                    w_old;
    logic signed [SUM_W-1:0]   w_new_sum;
    logic signed [LOGIT_W-1:0] w_avg;
    logic                      w_better;
    logic [FILL_W-1:0]         w_votes;
    logic                      w_mask_ok;
    logic                      w_cand;
    logic [RUN_W-1:0]          w_run;
    logic                      w_fire;

    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_commit   = w_decide && w_out_free;
    assign w_in_pack  = {i_in.logit_3, i_in.logit_2, i_in.logit_1, i_in.logit_0};

    // register writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_thresh    <= THRESH_RST;
            r_cfg_min_votes <= MIN_VOTES_RST;
            r_cfg_min_run   <= MIN_RUN_RST;
            r_cfg_holdoff   <= HOLDOFF_RST;
            r_cfg_mask      <= MASK_RST;
            r_cfg_en        <= ENABLE_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                REG_THRESH:    r_cfg_thresh    <= i_cfg.data;
                REG_MIN_VOTES: r_cfg_min_votes <= i_cfg.data[3:0];
                REG_MIN_RUN:   r_cfg_min_run   <= i_cfg.data[RUN_W-1:0];
                REG_HOLDOFF:   r_cfg_holdoff   <= i_cfg.data;
                REG_MASK:      r_cfg_mask      <= i_cfg.data[MASK_W-1:0];
                REG_ENABLE:    r_cfg_en        <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // history memories, read-first at the write pointer
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_logit_mem[r_wp]  <= w_in_pack;
            r_winner_mem[r_wp] <= i_in.frame_winner;
            r_old_pack         <= r_logit_mem[r_wp];
            r_old_winner       <= r_winner_mem[r_wp];
            r_in_pack          <= w_in_pack;
            r_in_winner        <= i_in.frame_winner;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (w_in_acc) n_state = ST_SUM;
            ST_SUM:    if (r_cls == LAST_CLS) n_state = ST_DECIDE;
            ST_DECIDE: if (w_commit) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready = 1'b0;
        w_sum_en   = 1'b0;
        w_decide   = 1'b0;
        unique case (r_state)
            ST_IDLE:   i_in.ready = 1'b1;
            ST_SUM:    w_sum_en   = 1'b1;
            ST_DECIDE: w_decide   = 1'b1;
            default: ;
        endcase
    end

    // shared sum / average / compare unit, one class per cycle
    assign w_lg_idx  = 2'(r_cls);
    assign w_lg_live = int'(r_cls) < NUM_LOGITS;
    assign w_lg      = w_lg_live ? t_logit'(r_in_pack[w_lg_idx*LOGIT_W +: LOGIT_W]) : '0;
    assign w_old     = (w_lg_live && r_old_valid)
                     ? t_logit'(r_old_pack[w_lg_idx*LOGIT_W +: LOGIT_W]) : '0;
    assign w_new_sum = r_sum[r_cls] + SUM_W'(w_lg) - SUM_W'(w_old);
    assign w_avg     = w_new_sum[SUM_W-1:SH];
    assign w_better  = (r_cls == '0) || (w_avg > r_best_val);

    // candidate and run decision
    assign w_votes   = r_votes[r_best];
    assign w_mask_ok = (int'(r_best) < MASK_W) && r_cfg_mask[2'(r_best)];
    assign w_cand    = r_cfg_en && w_mask_ok && (r_best_val >= r_cfg_thresh)
                    && (int'(w_votes) >= int'(r_cfg_min_votes));

    always_comb begin
        if (!w_cand) begin
            w_run = '0;
        end else if (r_run != '0 && r_last == r_best) begin
            w_run = (r_run == RUN_CAP) ? r_run : r_run + 1'b1;
        end else begin
            w_run = RUN_W'(1);
        end
    end

    assign w_fire = w_cand && (r_holdoff == '0) && (w_run >= r_cfg_min_run);

    always_comb begin
        n_wp        = r_wp;
        n_fill      = r_fill;
        n_old_valid = r_old_valid;
        n_cls       = r_cls;
        n_best      = r_best;
        n_best_val  = r_best_val;
        n_sum       = r_sum;
        n_votes     = r_votes;
        n_run       = r_run;
        n_last      = r_last;
        n_holdoff   = r_holdoff;
        n_out_valid = r_out_valid;
        n_fire      = r_fire;
        n_class     = r_class;
        n_conf      = r_conf;
        n_vote      = r_vote;

        if (o_out.valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        if (w_in_acc) begin
            n_old_valid = (r_fill == DEPTH_FILL);
            n_wp        = (r_wp == LAST_PTR) ? '0 : r_wp + 1'b1;
            n_cls       = '0;
            if (r_fill != DEPTH_FILL) begin
                n_fill = r_fill + 1'b1;
            end
        end

        if (w_sum_en) begin
            n_sum[r_cls] = w_new_sum;
            n_cls        = r_cls + 1'b1;
            if (w_better) begin
                n_best     = r_cls;
                n_best_val = w_avg;
            end
            // window vote counts: add the new winner, drop the overwritten one
            if (r_cls == '0) begin
                for (int c = 0; c < NUM_CLASSES; c++) begin
                    if ((int'(r_in_winner) == c)
                            && !(r_old_valid && int'(r_old_winner) == c)) begin
                        n_votes[c] = r_votes[c] + 1'b1;
                    end else if (!(int'(r_in_winner) == c)
                            && (r_old_valid && int'(r_old_winner) == c)) begin
                        n_votes[c] = r_votes[c] - 1'b1;
                    end
                end
            end
        end

        if (w_commit) begin
            n_out_valid = 1'b1;
            n_fire      = w_fire;
            n_class     = '0;
            n_conf      = '0;
            n_vote      = '0;
            if (w_cand) begin
                n_last = r_best;
            end
            if (w_fire) begin
                n_class   = CLASS_W'(r_best);
                n_conf    = r_best_val[LOGIT_W-1] ? '0 : r_best_val[CONF_W-1:0];
                n_vote    = VOTE_OUT_W'(w_votes);
                n_holdoff = r_cfg_holdoff;
                n_run     = '0;
            end else begin
                n_run = w_run;
                if (r_holdoff != '0) begin
                    n_holdoff = r_holdoff - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wp        <= '0;
            r_fill      <= '0;
            r_old_valid <= 1'b0;
            r_cls       <= '0;
            r_best      <= '0;
            r_best_val  <= '0;
            r_sum       <= '{default: '0};
            r_votes     <= '{default: '0};
            r_run       <= '0;
            r_last      <= '0;
            r_holdoff   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_fill      <= n_fill;
            r_old_valid <= n_old_valid;
            r_cls       <= n_cls;
            r_best      <= n_best;
            r_best_val  <= n_best_val;
            r_sum       <= n_sum;
            r_votes     <= n_votes;
            r_run       <= n_run;
            r_last      <= n_last;
            r_holdoff   <= n_holdoff;
            r_out_valid <= n_out_valid;
        end
    end

    // result word register
    always_ff @(posedge i_clk) begin
        r_fire  <= n_fire;
        r_class <= n_class;
        r_conf  <= n_conf;
        r_vote  <= n_vote;
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.fire        = r_fire;
    assign o_out.event_class = r_class;
    assign o_out.confidence  = r_conf;
    assign o_out.vote_count  = r_vote;

    // checks
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= DEPTH_FILL)
        else $error("fill count beyond window depth");

    a_accept_to_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_state == ST_SUM)
        else $error("accepted word did not start the class sweep");

    a_holdoff_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && w_fire) |=> r_holdoff == $past(r_cfg_holdoff))
        else $error("hold-off not loaded after detection");

endmodule

>>> test/tb_detection_vote_smoother_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_detection_vote_smoother_unit
// Self-checking bench for the detection vote smoother. Classifier frame
// words go in with random gaps. A scoreboard keeps its own moving sums,
// winner history, run and hold-off state and predicts one detection word
// per frame. Each result word is compared field by field in order. The
// register settings change between phases and include the extremes.
// ----------------------------------------------------------------------------
module tb_detection_vote_smoother_unit;
    import dvs_pkg::*;

    localparam int WIN          = WINDOW_DEPTH_DEF;
    localparam int AVG_SHIFT    = $clog2(WIN);
    localparam int IDLE_PCT     = 19;
    localparam int LONG_STALL   = 300;
    localparam int SETTLE       = 10;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_FRAMES = 135;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct {
        t_logit              lg [NUM_LOGITS];
        logic [WINNER_W-1:0] winner;
    } t_frame;

    typedef struct packed {
        logic                  fire;
        logic [CLASS_W-1:0]    cls;
        logic [CONF_W-1:0]     conf;
        logic [VOTE_OUT_W-1:0] votes;
    } t_detection;

    class detection_scoreboard;
        int                  class_sum [NUM_CLASSES_DEF];
        int                  logit_hist [WIN][NUM_CLASSES_DEF];
        logic [WINNER_W-1:0] winner_hist [WIN];
        int                  wr_ptr, filled, run_len, last_class, holdoff;
        int                  thresh, min_votes, min_run, holdoff_load, class_mask, enable;
        t_detection          pending_q [$];
        int                  errors;

        function new();
            foreach (class_sum[c]) class_sum[c] = 0;
            foreach (logit_hist[d, c]) logit_hist[d][c] = 0;
            wr_ptr       = 0;
            filled       = 0;
            run_len      = 0;
            last_class   = 0;
            holdoff      = 0;
            thresh       = int'(THRESH_RST);
            min_votes    = int'(MIN_VOTES_RST);
            min_run      = int'(MIN_RUN_RST);
            holdoff_load = int'(HOLDOFF_RST);
            class_mask   = int'(MASK_RST);
            enable       = int'(ENABLE_RST);
            errors       = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_THRESH:    thresh       = int'($signed(data));
                REG_MIN_VOTES: min_votes    = int'(data[3:0]);
                REG_MIN_RUN:   min_run      = int'(data[RUN_W-1:0]);
                REG_HOLDOFF:   holdoff_load = int'(data);
                REG_MASK:      class_mask   = int'(data[MASK_W-1:0]);
                REG_ENABLE:    enable       = int'(data[0]);
                default: ;
            endcase
        endfunction

        function void note_frame(t_frame f);
            int         avg, best, best_val, votes, run;
            bit         candidate, fire;
            t_detection d;
            for (int c = 0; c < NUM_CLASSES_DEF; c++) begin
                class_sum[c] = class_sum[c] + f.lg[c] - logit_hist[wr_ptr][c];
                logit_hist[wr_ptr][c] = int'(f.lg[c]);
            end
            winner_hist[wr_ptr] = f.winner;
            wr_ptr = (wr_ptr + 1) % WIN;
            if (filled < WIN) filled++;

            best = 0;
            best_val = 0;
            for (int c = 0; c < NUM_CLASSES_DEF; c++) begin
                avg = class_sum[c] >>> AVG_SHIFT;
                if (c == 0 || avg > best_val) begin
                    best_val = avg;
                    best = c;
                end
            end

            votes = 0;
            for (int k = 0; k < filled; k++)
                if (winner_hist[k] == best) votes++;

            candidate = enable != 0 && ((class_mask >> best) & 1) != 0
                        && best_val >= thresh && votes >= min_votes;
            if (!candidate)
                run = 0;
            else if (run_len != 0 && last_class == best)
                run = (run_len >= RUN_CAP) ? run_len : run_len + 1;
            else
                run = 1;
            fire = candidate && holdoff == 0 && run >= min_run;
            if (candidate) last_class = best;

            d = '0;
            if (fire) begin
                d.fire  = 1'b1;
                d.cls   = CLASS_W'(best);
                d.conf  = (best_val < 0) ? '0 : CONF_W'(best_val);
                d.votes = VOTE_OUT_W'(votes);
                holdoff = holdoff_load;
                run_len = 0;
            end else begin
                run_len = run;
                if (holdoff > 0) holdoff--;
            end
            pending_q.push_back(d);
        endfunction

        function void flag(string what, t_detection want, t_detection got);
            errors++;
            if (errors <= 10)
                $display("%t %s: expected fire=%0d class=%0d conf=%0d votes=%0d,",
                         $time, what, want.fire, want.cls, want.conf, want.votes,
                         " got fire=%0d class=%0d conf=%0d votes=%0d",
                         got.fire, got.cls, got.conf, got.votes);
        endfunction

        function void check_result(t_detection got);
            t_detection want;
            if (pending_q.size() == 0) begin
                flag("unexpected word", '0, got);
                return;
            end
            want = pending_q.pop_front();
            if (got.fire !== want.fire || got.cls !== want.cls
                || got.conf !== want.conf || got.votes !== want.votes)
                flag("bad word", want, got);
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    dvs_cfg_if cfg_if ();
    dvs_in_if  frame_if ();
    dvs_out_if det_if ();

    detection_scoreboard sb = new();

    bit          calm;
    logic        squeeze_req;
    logic        squeeze_done;
    int          stall_left;
    int unsigned cycle_count;

    detection_vote_smoother_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (frame_if),
        .o_out   (det_if)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("detection_vote_smoother_unit: mismatch");
            $finish;
        end
    end

    // result side ready, with one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            det_if.ready <= 1'b0;
            stall_left   <= 0;
            squeeze_done <= 1'b0;
        end else if (squeeze_req && !squeeze_done) begin
            squeeze_done <= 1'b1;
            stall_left   <= LONG_STALL;
            det_if.ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left   <= stall_left - 1;
            det_if.ready <= 1'b0;
        end else begin
            det_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin : watch
        t_frame     seen;
        t_detection got;
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready)
                sb.write_reg(cfg_if.index, cfg_if.data);
            if (frame_if.valid && frame_if.ready) begin
                seen.lg[0]  = frame_if.logit_0;
                seen.lg[1]  = frame_if.logit_1;
                seen.lg[2]  = frame_if.logit_2;
                seen.lg[3]  = frame_if.logit_3;
                seen.winner = frame_if.frame_winner;
                sb.note_frame(seen);
            end
            if (det_if.valid && det_if.ready) begin
                got.fire  = det_if.fire;
                got.cls   = det_if.event_class;
                got.conf  = det_if.confidence;
                got.votes = det_if.vote_count;
                sb.check_result(got);
            end
        end
    end

    function automatic t_frame frame_of(int l0, int l1, int l2, int l3, int w);
        t_frame f;
        f.lg[0]  = t_logit'(l0);
        f.lg[1]  = t_logit'(l1);
        f.lg[2]  = t_logit'(l2);
        f.lg[3]  = t_logit'(l3);
        f.winner = WINNER_W'(w);
        return f;
    endfunction

    task automatic send_frame(t_frame f);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            frame_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        frame_if.valid        <= 1'b1;
        frame_if.logit_0      <= f.lg[0];
        frame_if.logit_1      <= f.lg[1];
        frame_if.logit_2      <= f.lg[2];
        frame_if.logit_3      <= f.lg[3];
        frame_if.frame_winner <= f.winner;
        @(posedge i_clk);
        while (!frame_if.ready) @(posedge i_clk);
    endtask

    // valid stays up across back to back writes, apply_settings drops it
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
    endtask

    // upper bits of the narrow registers carry junk
    task automatic apply_settings(int th, int votes, int run, int hold, int msk, int en);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom_range(0, 255));
        write_reg(REG_THRESH, CFG_DATA_W'(th));
        write_reg(REG_MIN_VOTES, {junk[7:4], 4'(votes)});
        write_reg(REG_MIN_RUN, {junk[3:0], 4'(run)});
        write_reg(REG_HOLDOFF, CFG_DATA_W'(hold));
        junk = CFG_DATA_W'($urandom_range(0, 255));
        write_reg(REG_MASK, {junk[7:4], 4'(msk)});
        write_reg(REG_ENABLE, {junk[7:1], 1'(en)});
        cfg_if.valid <= 1'b0;
    endtask

    task automatic wait_idle();
        frame_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // segments with one dominant class, some segments pure noise
    task automatic feed_random(int count, int squeeze_at);
        t_frame f;
        int     dom, seg_left;
        bit     noisy;
        dom = 0;
        seg_left = 0;
        noisy = 1'b0;
        for (int i = 0; i < count; i++) begin
            if (i == squeeze_at) squeeze_req <= 1'b1;
            if (seg_left == 0) begin
                dom = $urandom_range(0, 3);
                seg_left = $urandom_range(3, 30);
                noisy = $urandom_range(0, 99) < 25;
            end
            seg_left--;
            for (int c = 0; c < NUM_LOGITS; c++) begin
                if (noisy)
                    f.lg[c] = t_logit'($urandom_range(0, 255));
                else if (c == dom)
                    f.lg[c] = t_logit'($urandom_range(20, 127));
                else
                    f.lg[c] = t_logit'(int'($urandom_range(0, 168)) - 128);
            end
            if (noisy || $urandom_range(0, 99) < 15)
                f.winner = WINNER_W'($urandom_range(0, 3));
            else
                f.winner = WINNER_W'(dom);
            send_frame(f);
        end
    endtask

    initial begin
        i_rst_n               = 1'b0;
        calm                  = 1'b0;
        squeeze_req           = 1'b0;
        squeeze_done          = 1'b0;
        stall_left            = 0;
        cycle_count           = 0;
        cfg_if.valid          = 1'b0;
        cfg_if.index          = '0;
        cfg_if.data           = '0;
        frame_if.valid        = 1'b0;
        frame_if.logit_0      = '0;
        frame_if.logit_1      = '0;
        frame_if.logit_2      = '0;
        frame_if.logit_3      = '0;
        frame_if.frame_winner = '0;
        det_if.ready          = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: ties, a class 3 detection, then hold-off
        send_frame(frame_of(0, 0, 0, 0, 0));
        send_frame(frame_of(0, 0, 0, 0, 1));
        send_frame(frame_of(127, -128, 127, -128, 2));
        repeat (7) send_frame(frame_of(-128, -128, -128, 127, 3));
        repeat (3) send_frame(frame_of(-128, -128, 127, -128, 2));
        send_frame(frame_of(-1, 85, -86, 1, 1));
        send_frame(frame_of(-86, -1, 85, 0, 0));
        wait_idle();

        // everything passes: fires every frame, negative scores clamp
        apply_settings(-128, 0, 0, 0, 15, 1);
        for (int i = 0; i < 9; i++) send_frame(frame_of(-128, -128, -128, -128, i % 4));
        send_frame(frame_of(127, 127, 127, 127, 3));
        wait_idle();

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: apply_settings(-128, 0, 15, 40, 15, 1);
                1: begin
                    write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom_range(0, 255)));
                    write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom_range(0, 255)));
                    apply_settings(127, 8, 15, 255, 0, 0);
                end
                2: apply_settings(40, 5, 2, 12, 15, 1);
                default: apply_settings(
                    ($urandom_range(0, 99) < 70) ? $urandom_range(0, 80) : $urandom_range(0, 255),
                    $urandom_range(0, 8),
                    $urandom_range(0, 15),
                    ($urandom_range(0, 99) < 70) ? $urandom_range(0, 20) : $urandom_range(0, 255),
                    $urandom_range(0, 15),
                    int'($urandom_range(0, 9) != 0));
            endcase
            calm = (p == 4);
            feed_random(PHASE_FRAMES, (p == 3) ? 40 : -1);
            calm = 1'b0;
            wait_idle();
        end

        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("detection_vote_smoother_unit: match");
        else
            $display("detection_vote_smoother_unit: mismatch");
        $finish;
    end

endmodule
